### rtl/rgbyuv_pkg.sv
`default_nettype none
package rgbyuv_pkg;

	// configuration register widths and indexes
	localparam int PPR_W       = 12;
	localparam int ROWS_W      = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_PAIRS_PER_ROW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS    = 1'b1;

	localparam logic [PPR_W-1:0]  PPR_RESET  = 12'd320;
	localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd480;

	// luma coefficients, 8.16 fixed point
	localparam logic [23:0] COEF_B      = 24'd6416;
	localparam logic [23:0] COEF_G      = 24'd33039;
	localparam logic [23:0] COEF_R      = 24'd16829;
	localparam logic [23:0] LUMA_OFFSET = 24'h108000;

	// chroma constants
	localparam logic [24:0]        CHROMA_SCALE = 25'd38155;
	localparam logic [9:0]         LUMA_FLOOR2  = 10'd32;
	localparam logic signed [27:0] U_MULT       = 28'sd507;
	localparam logic signed [27:0] V_MULT       = 28'sd642;
	// chroma offset plus rounding half
	localparam logic signed [27:0] CHROMA_BIAS  = 28'sh0808000;

	// one pair with its row class, passed from front to back
	typedef struct packed {
		logic [7:0] blue_a;
		logic [7:0] green_a;
		logic [7:0] red_a;
		logic [7:0] blue_b;
		logic [7:0] green_b;
		logic [7:0] red_b;
		logic       even_row;
		logic       frame_end;
	} pair_word_t;

endpackage
`default_nettype wire

### rtl/rgbyuv_front.sv
`default_nettype none
module rgbyuv_front #(
	parameter int MAX_PAIRS_PER_ROW = 2048,
	parameter int MAX_ROWS          = 4096
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [rgbyuv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rgbyuv_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                               in_valid,
	input  wire logic                               queue_full,
	input  wire logic [7:0]                         blue_a,
	input  wire logic [7:0]                         green_a,
	input  wire logic [7:0]                         red_a,
	input  wire logic [7:0]                         blue_b,
	input  wire logic [7:0]                         green_b,
	input  wire logic [7:0]                         red_b,
	output logic                                    push,
	output rgbyuv_pkg::pair_word_t                  push_word
);

	localparam int PW = (MAX_PAIRS_PER_ROW > 1) ? $clog2(MAX_PAIRS_PER_ROW) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [rgbyuv_pkg::PPR_W-1:0]  ppr_q;
	logic [rgbyuv_pkg::ROWS_W-1:0] rows_q;
	logic [PW-1:0]                 pair_cnt_q;
	logic [RW-1:0]                 row_cnt_q;
	logic [31:0]                   ppr_eff;
	logic [31:0]                   rows_eff;
	logic                          last_pair;
	logic                          last_row;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q  <= rgbyuv_pkg::PPR_RESET;
			rows_q <= rgbyuv_pkg::ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rgbyuv_pkg::REG_PAIRS_PER_ROW: ppr_q <= cfg_data[rgbyuv_pkg::PPR_W-1:0];
				rgbyuv_pkg::REG_FRAME_ROWS:    rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective lengths: zero counts as one, oversize clamps
	always_comb begin
		if (ppr_q == '0)
			ppr_eff = 32'd1;
		else if (32'(ppr_q) > 32'(MAX_PAIRS_PER_ROW))
			ppr_eff = 32'(MAX_PAIRS_PER_ROW);
		else
			ppr_eff = 32'(ppr_q);
		if (rows_q == '0)
			rows_eff = 32'd1;
		else if (32'(rows_q) > 32'(MAX_ROWS))
			rows_eff = 32'(MAX_ROWS);
		else
			rows_eff = 32'(rows_q);
	end

	assign last_pair = 32'(pair_cnt_q) >= (ppr_eff - 32'd1);
	assign last_row  = 32'(row_cnt_q) >= (rows_eff - 32'd1);

	assign push = in_valid && !queue_full;

	// classify the word
	always_comb begin
		push_word.blue_a    = blue_a;
		push_word.green_a   = green_a;
		push_word.red_a     = red_a;
		push_word.blue_b    = blue_b;
		push_word.green_b   = green_b;
		push_word.red_b     = red_b;
		push_word.even_row  = ~row_cnt_q[0];
		push_word.frame_end = last_pair && last_row;
	end

	// column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_cnt_q <= '0;
			row_cnt_q  <= '0;
		end else if (push) begin
			if (last_pair) begin
				pair_cnt_q <= '0;
				row_cnt_q  <= last_row ? '0 : row_cnt_q + 1'b1;
			end else begin
				pair_cnt_q <= pair_cnt_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/rgbyuv_fifo.sv
`default_nettype none
module rgbyuv_fifo (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire rgbyuv_pkg::pair_word_t push_word,
	input  wire logic                   pop,
	output rgbyuv_pkg::pair_word_t      pop_word,
	output logic                        full,
	output logic                        empty
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	rgbyuv_pkg::pair_word_t mem_q [DEPTH];
	logic [AW-1:0]          wr_ptr_q;
	logic [AW-1:0]          rd_ptr_q;
	logic [AW:0]            count_q;

	assign full     = count_q == (AW+1)'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_word = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_word;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### rtl/rgbyuv_back.sv
`default_nettype none
module rgbyuv_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   queue_empty,
	input  wire rgbyuv_pkg::pair_word_t pop_word,
	output logic                        pop,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [7:0]                  luma_a,
	output logic [7:0]                  luma_b,
	output logic [7:0]                  chroma_u,
	output logic [7:0]                  chroma_v,
	output logic                        chroma_valid,
	output logic                        frame_end
);

	logic advance;

	logic              valid_s1, valid_s2, valid_s3;
	logic [7:0]        ya_s1, yb_s1, ya_s2, yb_s2, ya_s3, yb_s3;
	logic [8:0]        bsum_s1, rsum_s1;
	logic              even_s1, even_s2, even_s3;
	logic              fend_s1, fend_s2, fend_s3;
	logic signed [26:0] diff_u_s2, diff_v_s2;
	logic signed [27:0] prod_u_s3, prod_v_s3;

	logic [23:0]        sum_a, sum_b;
	logic [9:0]         ysum;
	logic [24:0]        scaled;
	logic signed [16:0] sh_u, sh_v;
	logic signed [27:0] rnd_u, rnd_v;
	logic [7:0]         sat_u, sat_v;

	logic       out_valid_q;
	logic [7:0] luma_a_q, luma_b_q, chroma_u_q, chroma_v_q;
	logic       chroma_valid_q, frame_end_q;

	// whole pipe moves when the output register is free or being taken
	assign advance = !out_valid_q || !out_stall;
	assign pop     = advance && !queue_empty;

	// stage 1 logic: luma of both pixels
	always_comb begin
		sum_a = rgbyuv_pkg::COEF_B * 24'(pop_word.blue_a)
			+ rgbyuv_pkg::COEF_G * 24'(pop_word.green_a)
			+ rgbyuv_pkg::COEF_R * 24'(pop_word.red_a)
			+ rgbyuv_pkg::LUMA_OFFSET;
		sum_b = rgbyuv_pkg::COEF_B * 24'(pop_word.blue_b)
			+ rgbyuv_pkg::COEF_G * 24'(pop_word.green_b)
			+ rgbyuv_pkg::COEF_R * 24'(pop_word.red_b)
			+ rgbyuv_pkg::LUMA_OFFSET;
	end

	// stage 2 logic: luma-scaled term and color differences
	always_comb begin
		ysum   = 10'(ya_s1) + 10'(yb_s1) - rgbyuv_pkg::LUMA_FLOOR2;
		scaled = 25'(ysum) * rgbyuv_pkg::CHROMA_SCALE;
	end

	// stage 3 logic: floor shift by 10
	assign sh_u = diff_u_s2[26:10];
	assign sh_v = diff_v_s2[26:10];

	// output logic: offset, round, saturate
	always_comb begin
		rnd_u = prod_u_s3 + rgbyuv_pkg::CHROMA_BIAS;
		rnd_v = prod_v_s3 + rgbyuv_pkg::CHROMA_BIAS;
		if (!even_s3 || rnd_u[27])
			sat_u = 8'd0;
		else if (rnd_u[26:24] != 3'd0)
			sat_u = 8'd255;
		else
			sat_u = rnd_u[23:16];
		if (!even_s3 || rnd_v[27])
			sat_v = 8'd0;
		else if (rnd_v[26:24] != 3'd0)
			sat_v = 8'd255;
		else
			sat_v = rnd_v[23:16];
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (advance) begin
			ya_s1   <= sum_a[23:16];
			yb_s1   <= sum_b[23:16];
			bsum_s1 <= 9'(pop_word.blue_a) + 9'(pop_word.blue_b);
			rsum_s1 <= 9'(pop_word.red_a) + 9'(pop_word.red_b);
			even_s1 <= pop_word.even_row;
			fend_s1 <= pop_word.frame_end;

			ya_s2     <= ya_s1;
			yb_s2     <= yb_s1;
			even_s2   <= even_s1;
			fend_s2   <= fend_s1;
			diff_u_s2 <= $signed(27'({bsum_s1, 15'b0})) - $signed(27'(scaled));
			diff_v_s2 <= $signed(27'({rsum_s1, 15'b0})) - $signed(27'(scaled));

			ya_s3     <= ya_s2;
			yb_s3     <= yb_s2;
			even_s3   <= even_s2;
			fend_s3   <= fend_s2;
			prod_u_s3 <= 28'(sh_u) * rgbyuv_pkg::U_MULT;
			prod_v_s3 <= 28'(sh_v) * rgbyuv_pkg::V_MULT;

			luma_a_q       <= ya_s3;
			luma_b_q       <= yb_s3;
			chroma_u_q     <= sat_u;
			chroma_v_q     <= sat_v;
			chroma_valid_q <= even_s3;
			frame_end_q    <= fend_s3;
		end
	end

	assign out_valid    = out_valid_q;
	assign luma_a       = luma_a_q;
	assign luma_b       = luma_b_q;
	assign chroma_u     = chroma_u_q;
	assign chroma_v     = chroma_v_q;
	assign chroma_valid = chroma_valid_q;
	assign frame_end    = frame_end_q;

endmodule
`default_nettype wire

### rtl/rgb24_to_yuv420_converter_top.sv
// RGB24 to YUV 4:2:0 converter, BT.601 studio range. One word in is a horizontal
// pair of BGR pixels in scan order; one word out carries both luma samples and, on
// even rows, one U and one V sample (zero with chroma_valid low on odd rows), plus
// a frame_end flag on the last pair of the frame. Sustained rate is one pair per
// clock while out_stall stays low: the front counts columns and rows and tags each
// word, a four-deep queue holds it, and a four-stage back pipeline (luma, chroma
// difference, chroma multiply, round and saturate) works on one word per stage.
// The user must write pairs_per_row and frame_rows through cfg_we/cfg_index/
// cfg_data only while the block is idle; the block itself does not enforce this.
// Zero counts as one and values above the maximum parameters clamp to them.
`default_nettype none
module rgb24_to_yuv420_converter_top #(
	parameter int MAX_PAIRS_PER_ROW = 2048,
	parameter int MAX_ROWS          = 4096
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rgbyuv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rgbyuv_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [7:0]                        blue_a,
	input  wire logic [7:0]                        green_a,
	input  wire logic [7:0]                        red_a,
	input  wire logic [7:0]                        blue_b,
	input  wire logic [7:0]                        green_b,
	input  wire logic [7:0]                        red_b,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [7:0]                             luma_a,
	output logic [7:0]                             luma_b,
	output logic [7:0]                             chroma_u,
	output logic [7:0]                             chroma_v,
	output logic                                   chroma_valid,
	output logic                                   frame_end
);

	logic                   push;
	logic                   pop;
	logic                   queue_full;
	logic                   queue_empty;
	rgbyuv_pkg::pair_word_t push_word;
	rgbyuv_pkg::pair_word_t pop_word;

	assign in_stall = queue_full;

	// counters and classification
	rgbyuv_front #(
		.MAX_PAIRS_PER_ROW (MAX_PAIRS_PER_ROW),
		.MAX_ROWS          (MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.queue_full (queue_full),
		.blue_a     (blue_a),
		.green_a    (green_a),
		.red_a      (red_a),
		.blue_b     (blue_b),
		.green_b    (green_b),
		.red_b      (red_b),
		.push       (push),
		.push_word  (push_word)
	);

	// decoupling queue
	rgbyuv_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	// color math pipeline
	rgbyuv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (queue_empty),
		.pop_word     (pop_word),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.luma_a       (luma_a),
		.luma_b       (luma_b),
		.chroma_u     (chroma_u),
		.chroma_v     (chroma_v),
		.chroma_valid (chroma_valid),
		.frame_end    (frame_end)
	);

endmodule
`default_nettype wire

### rtl/rgbyuv_checker.sv
`default_nettype none
module rgbyuv_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] luma_a,
	input wire logic [7:0] luma_b,
	input wire logic [7:0] chroma_u,
	input wire logic [7:0] chroma_v,
	input wire logic       chroma_valid
);

	// a stalled word stays
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out word dropped while stalled");

	// a stalled word keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(luma_a) && $stable(luma_b)
			&& $stable(chroma_u) && $stable(chroma_v))
		else $error("out payload changed while stalled");

	// luma is studio range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> luma_a >= 8'd16 && luma_a <= 8'd235
			&& luma_b >= 8'd16 && luma_b <= 8'd235)
		else $error("luma out of studio range");

	// odd rows carry zero chroma
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !chroma_valid |-> chroma_u == 8'd0 && chroma_v == 8'd0)
		else $error("chroma not zero on odd row");

endmodule

bind rgb24_to_yuv420_converter_top rgbyuv_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.luma_a       (luma_a),
	.luma_b       (luma_b),
	.chroma_u     (chroma_u),
	.chroma_v     (chroma_v),
	.chroma_valid (chroma_valid)
);
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

	localparam int MAX_PAIRS   = 2048;
	localparam int MAX_LINES   = 4096;
	localparam int Y_COEF_B    = 6416;
	localparam int Y_COEF_G    = 33039;
	localparam int Y_COEF_R    = 16829;
	localparam int Y_OFS       = 'h108000;
	localparam int CH_SCALE    = 38155;
	localparam int U_GAIN      = 507;
	localparam int V_GAIN      = 642;
	localparam int CH_OFS      = 'h800000;
	localparam int CH_HALF     = 'h8000;
	localparam int HOLD_CYCLES = 200;
	localparam int QUIET_LIMIT = 4000;

	// b, g, r of the first pixel from the top bits down, then the second pixel
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] g0;
		logic [7:0] r0;
		logic [7:0] b1;
		logic [7:0] g1;
		logic [7:0] r1;
	} bgr_pair_t;

	typedef struct packed {
		logic [7:0] y0;
		logic [7:0] y1;
		logic [7:0] u;
		logic [7:0] v;
		logic       cv;
		logic       fe;
	} yuv_word_t;

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              cfg_we    = 1'b0;
	logic [rgbyuv_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rgbyuv_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                              in_valid  = 1'b0;
	logic                              in_stall;
	logic [7:0]                        blue_a    = '0;
	logic [7:0]                        green_a   = '0;
	logic [7:0]                        red_a     = '0;
	logic [7:0]                        blue_b    = '0;
	logic [7:0]                        green_b   = '0;
	logic [7:0]                        red_b     = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic [7:0]                        luma_a;
	logic [7:0]                        luma_b;
	logic [7:0]                        chroma_u;
	logic [7:0]                        chroma_v;
	logic                              chroma_valid;
	logic                              frame_end;

	// pairs waiting to be sent and yuv words still due from the block
	bgr_pair_t pair_q[$];
	yuv_word_t yuv_due_q[$];

	// shadow of the frame geometry and the scan position
	logic [rgbyuv_pkg::PPR_W-1:0]  cfg_ppr  = rgbyuv_pkg::PPR_RESET;
	logic [rgbyuv_pkg::ROWS_W-1:0] cfg_rows = rgbyuv_pkg::ROWS_RESET;
	int                            pair_pos = 0;
	int                            line_pos = 0;

	bit        in_taken     = 1'b0;
	bit        hold_done    = 1'b0;
	int        hold_left    = 0;
	int        sent_cnt     = 0;
	int        res_cnt      = 0;
	int        quiet_cycles = 0;
	int        mismatches   = 0;
	yuv_word_t got_w;
	yuv_word_t want_w;

	rgb24_to_yuv420_converter_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.blue_a      (blue_a),
		.green_a     (green_a),
		.red_a       (red_a),
		.blue_b      (blue_b),
		.green_b     (green_b),
		.red_b       (red_b),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.luma_a      (luma_a),
		.luma_b      (luma_b),
		.chroma_u    (chroma_u),
		.chroma_v    (chroma_v),
		.chroma_valid(chroma_valid),
		.frame_end   (frame_end)
	);

	initial forever #5 clk = ~clk;

	// one chroma sample: floor shift, gain, offset, round and clamp
	function automatic logic [7:0] chroma_of(int diff, int gain);
		int acc;
		acc = ((diff >>> 10) * gain + CH_OFS + CH_HALF) >>> 16;
		if (acc < 0)
			return 8'd0;
		if (acc > 255)
			return 8'd255;
		return acc[7:0];
	endfunction

	// expected yuv word for one pair, advancing the scan position
	function automatic yuv_word_t convert_pair(bgr_pair_t p);
		int        ba, ga, ra, bb, gb, rb, ya, yb, scaled, ppr_eff, rows_eff;
		bit        last_pair, last_line;
		yuv_word_t w;
		ba = p.b0;
		ga = p.g0;
		ra = p.r0;
		bb = p.b1;
		gb = p.g1;
		rb = p.r1;
		ppr_eff = (cfg_ppr == 0) ? 1 : ((cfg_ppr > MAX_PAIRS) ? MAX_PAIRS : int'(cfg_ppr));
		rows_eff = (cfg_rows == 0) ? 1 : ((cfg_rows > MAX_LINES) ? MAX_LINES : int'(cfg_rows));
		ya = (Y_COEF_B * ba + Y_COEF_G * ga + Y_COEF_R * ra + Y_OFS) >>> 16;
		yb = (Y_COEF_B * bb + Y_COEF_G * gb + Y_COEF_R * rb + Y_OFS) >>> 16;
		w.y0 = ya[7:0];
		w.y1 = yb[7:0];
		w.cv = (line_pos % 2) == 0;
		w.u = 8'd0;
		w.v = 8'd0;
		// chroma on even rows only, from the pair sums against the luma
		if (w.cv) begin
			scaled = (ya + yb - 32) * CH_SCALE;
			w.u = chroma_of((ba + bb) * 32768 - scaled, U_GAIN);
			w.v = chroma_of((ra + rb) * 32768 - scaled, V_GAIN);
		end
		last_pair = pair_pos >= ppr_eff - 1;
		last_line = line_pos >= rows_eff - 1;
		w.fe = last_pair && last_line;
		if (last_pair) begin
			pair_pos = 0;
			line_pos = last_line ? 0 : line_pos + 1;
		end else begin
			pair_pos++;
		end
		return w;
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic queue_random(int n);
		bgr_pair_t p;
		for (int i = 0; i < n; i++) begin
			p.b0 = rand_byte();
			p.g0 = rand_byte();
			p.r0 = rand_byte();
			p.b1 = rand_byte();
			p.g1 = rand_byte();
			p.r1 = rand_byte();
			pair_q.push_back(p);
		end
	endtask

	// color extremes: black, white, primaries, split pairs, alternating bits
	task automatic push_directed();
		pair_q.push_back(48'h000000_000000);
		pair_q.push_back(48'hFFFFFF_FFFFFF);
		pair_q.push_back(48'hFF0000_FF0000);
		pair_q.push_back(48'h00FF00_00FF00);
		pair_q.push_back(48'h0000FF_0000FF);
		pair_q.push_back(48'h000000_FFFFFF);
		pair_q.push_back(48'hFFFFFF_000000);
		pair_q.push_back(48'hFFFF00_00FFFF);
		pair_q.push_back(48'hAA55AA_55AA55);
		pair_q.push_back(48'h00FFFF_FF0000);
	endtask

	// sender pauses until every due word has come back
	task automatic wait_drained();
		while (pair_q.size() != 0 || yuv_due_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [rgbyuv_pkg::CFG_IDX_W-1:0] idx,
		logic [rgbyuv_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == rgbyuv_pkg::REG_PAIRS_PER_ROW)
			cfg_ppr = val[rgbyuv_pkg::PPR_W-1:0];
		else
			cfg_rows = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// input side: a word is taken at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			yuv_due_q.push_back(convert_pair({blue_a, green_a, red_a, blue_b, green_b, red_b}));
			pair_q.delete(0);
			in_taken = 1'b1;
			sent_cnt++;
		end
	end

	// input side: offer the next word at the falling edge, hold it while stalled
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			in_taken = 1'b0;
			if (pair_q.size() == 0 || (sent_cnt % 512 < 384 && $urandom_range(0, 99) < 10)) begin
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				{blue_a, green_a, red_a, blue_b, green_b, red_b} <= pair_q[0];
			end
		end
	end

	// output side: random stalls, one long hold-off so the block backs up
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
		end else if (!hold_done && res_cnt >= 100) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (res_cnt % 512 < 384) && ($urandom_range(0, 99) < 10);
		end
	end

	// output side: compare each word with the oldest due word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			res_cnt++;
			got_w = {luma_a, luma_b, chroma_u, chroma_v, chroma_valid, frame_end};
			if (yuv_due_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected yuv word %h at %0t", got_w, $time);
				mismatches++;
			end else begin
				want_w = yuv_due_q.pop_front();
				if (got_w !== want_w) begin
					if (mismatches < 10)
						$display({"word %0d: expected y %0d/%0d u %0d v %0d cv %b fe %b,",
							" got y %0d/%0d u %0d v %0d cv %b fe %b"}, res_cnt,
							want_w.y0, want_w.y1, want_w.u, want_w.v, want_w.cv, want_w.fe,
							got_w.y0, got_w.y1, got_w.u, got_w.v, got_w.cv, got_w.fe);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset geometry: color extremes on an even row, then across two row ends
		push_directed();
		queue_random(700);

		// shrink the frame mid-row: the column counter past the new end closes the row
		wait_drained();
		write_reg(rgbyuv_pkg::REG_PAIRS_PER_ROW, 13'd3);
		write_reg(rgbyuv_pkg::REG_FRAME_ROWS, 13'd4);
		queue_random(30);

		// zero lengths count as one, so every word ends a frame
		wait_drained();
		write_reg(rgbyuv_pkg::REG_PAIRS_PER_ROW, 13'd0);
		write_reg(rgbyuv_pkg::REG_FRAME_ROWS, 13'd0);
		queue_random(8);

		// one pair per row, two rows: even and odd rows alternate
		wait_drained();
		write_reg(rgbyuv_pkg::REG_PAIRS_PER_ROW, 13'd1);
		write_reg(rgbyuv_pkg::REG_FRAME_ROWS, 13'd2);
		push_directed();
		queue_random(10);

		// oversize row: bit 12 is dropped, the row runs long with no frame end
		wait_drained();
		write_reg(rgbyuv_pkg::REG_PAIRS_PER_ROW, 13'h1FFF);
		write_reg(rgbyuv_pkg::REG_FRAME_ROWS, 13'd1);
		queue_random(250);

		// oversize frame: the long row closes at once, then rows run on
		wait_drained();
		write_reg(rgbyuv_pkg::REG_PAIRS_PER_ROW, 13'd1);
		write_reg(rgbyuv_pkg::REG_FRAME_ROWS, 13'h1FFF);
		queue_random(250);

		// small random frames, now and then a zero length
		repeat (7) begin
			wait_drained();
			write_reg(rgbyuv_pkg::REG_PAIRS_PER_ROW,
				13'(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12)));
			write_reg(rgbyuv_pkg::REG_FRAME_ROWS,
				13'(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 9)));
			queue_random(60);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && yuv_due_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/rgbyuv_pkg.sv
rtl/rgbyuv_front.sv
rtl/rgbyuv_fifo.sv
rtl/rgbyuv_back.sv
rtl/rgb24_to_yuv420_converter_top.sv
rtl/rgbyuv_checker.sv
tb/testbench.sv
